// File: rtl/jjy_pkg.sv
// shared types, codes and a helper function for the jjy time code generator
// no dependencies; every rtl file refers to it by scoped names

package jjy_pkg;

  // symbol codes on the output
  localparam logic [1:0] SYM_ZERO   = 2'd0;
  localparam logic [1:0] SYM_ONE    = 2'd1;
  localparam logic [1:0] SYM_MARKER = 2'd2;

  // operation codes on the input
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_MARKER_MS = 2'd0;
  localparam logic [1:0] REG_ONE_MS    = 2'd1;
  localparam logic [1:0] REG_ZERO_MS   = 2'd2;

  // register reset values
  localparam logic [9:0] MARKER_MS_RESET = 10'd200;
  localparam logic [9:0] ONE_MS_RESET    = 10'd500;
  localparam logic [9:0] ZERO_MS_RESET   = 10'd800;

  // time limits in bcd
  localparam logic [6:0] MINUTE_LAST_BCD = 7'h59;
  localparam logic [5:0] HOUR_LAST_BCD   = 6'h23;
  localparam logic [9:0] DAY_LAST_BCD    = 10'h365;
  localparam logic [6:0] QUIET_MIN_A     = 7'h15;
  localparam logic [6:0] QUIET_MIN_B     = 7'h45;

  localparam logic [5:0] SECOND_LAST  = 6'd59;
  localparam logic [2:0] WEEKDAY_LAST = 3'd6;

  // current time state
  typedef struct packed {
    logic [5:0] second;
    logic [6:0] minute;
    logic [5:0] hour;
    logic [9:0] day;
    logic [7:0] year;
    logic [2:0] weekday;
    logic       resync;
  } time_state_t;

  // carrier widths from the configuration registers
  typedef struct packed {
    logic [9:0] marker_ms;
    logic [9:0] one_ms;
    logic [9:0] zero_ms;
  } widths_t;

  // one result item, last field in the low bits
  typedef struct packed {
    logic       resync_request;
    logic [5:0] position;
    logic [9:0] high_ms;
    logic [1:0] symbol;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);

  // binary 0..399 to three bcd digits (hundreds held in two bits)
  function automatic logic [11:0] bin_to_bcd3(input logic [8:0] v);
    logic [1:0] hun;
    logic [6:0] rem;
    logic [3:0] ten;
    logic [3:0] one;
    if (v >= 9'd300) begin
      hun = 2'd3;
      rem = 7'(v - 9'd300);
    end else if (v >= 9'd200) begin
      hun = 2'd2;
      rem = 7'(v - 9'd200);
    end else if (v >= 9'd100) begin
      hun = 2'd1;
      rem = 7'(v - 9'd100);
    end else begin
      hun = 2'd0;
      rem = v[6:0];
    end
    ten = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 7'(k * 10)) ten = 4'(k);
    end
    one = 4'(rem - 7'(ten) * 7'd10);
    return {2'b00, hun, ten, one};
  endfunction

endpackage

// File: rtl/jjy_time_code_generator_unit.sv
// top level of the jjy time code generator
// depends on jjy_pkg, jjy_timekeeper, jjy_symbol and jjy_out_skid
//
// usage
//   input channel (s_*): one transaction is either a tick (s_tuser = 0) or a
//   time load (s_tuser = 1) with year, day of year, hour, minute, second and
//   weekday in s_tdata. a load gives no result; a tick gives one symbol.
//   output channel (m_*): symbol code, carrier-on width in ms, second position
//   and the resync request flag as it stands after the tick.
//   config port: cfg_we writes cfg_data into register cfg_index (marker, one,
//   zero widths); write only while no transaction is in flight.
// timing
//   a tick accepted at one edge shows its result on m_* after that edge if no
//   older result waits. state update and symbol select sit between the time and
//   result registers: one transaction per cycle is taken while s_tready is high.
// reset
//   rst clears the time to day one 00:00:00, weekday 0, widths to 200/500/800
//   ms, and empties the output buffer.
// stall
//   when m_tready is low the result register holds and a skid register takes
//   one more result; s_tready drops only while the skid register is full.

module jjy_time_code_generator_unit (
  input  logic        clk,
  input  logic        rst,
  // input transactions
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, low bit up: set_year[6:0], set_day_of_year[15:7], set_hour[20:16],
  // set_minute[26:21], set_second[32:27], set_weekday[35:33], zero pad[39:36]
  input  logic [39:0] s_tdata,
  // s_tuser: operation (0 = tick, 1 = load)
  input  logic        s_tuser,
  // result transactions
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, low bit up: symbol[1:0], high_ms[11:2], position[17:12],
  // resync_request[18], zero pad[23:19]
  output logic [23:0] m_tdata,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  jjy_pkg::widths_t     widths;
  jjy_pkg::time_state_t st;
  jjy_pkg::result_t     result;
  logic                 accept;
  logic                 tick;
  logic                 load;
  logic                 resync_next;
  logic                 space;
  logic [jjy_pkg::RESULT_BITS-1:0] out_bits;

  assign s_tready = space;
  assign accept   = s_tvalid && s_tready;
  assign tick     = accept && (s_tuser == jjy_pkg::OP_TICK);
  assign load     = accept && (s_tuser == jjy_pkg::OP_LOAD);

  // width registers
  always_ff @(posedge clk) begin
    if (rst) begin
      widths.marker_ms <= jjy_pkg::MARKER_MS_RESET;
      widths.one_ms    <= jjy_pkg::ONE_MS_RESET;
      widths.zero_ms   <= jjy_pkg::ZERO_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jjy_pkg::REG_MARKER_MS: widths.marker_ms <= cfg_data;
        jjy_pkg::REG_ONE_MS:    widths.one_ms    <= cfg_data;
        jjy_pkg::REG_ZERO_MS:   widths.zero_ms   <= cfg_data;
        default: begin
          // index outside the register list: ignored
        end
      endcase
    end
  end

  // time state and its advance
  jjy_timekeeper u_time (
    .clk             (clk),
    .rst             (rst),
    .tick            (tick),
    .load            (load),
    .set_year        (s_tdata[6:0]),
    .set_day_of_year (s_tdata[15:7]),
    .set_hour        (s_tdata[20:16]),
    .set_minute      (s_tdata[26:21]),
    .set_second      (s_tdata[32:27]),
    .set_weekday     (s_tdata[35:33]),
    .st              (st),
    .resync_next     (resync_next)
  );

  // symbol for the second position before the advance
  jjy_symbol u_sym (
    .st       (st),
    .widths   (widths),
    .symbol   (result.symbol),
    .high_ms  (result.high_ms),
    .position (result.position)
  );

  // the flag reported is the one left behind by this tick
  assign result.resync_request = resync_next;

  jjy_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (tick),
    .push_data (result),
    .space     (space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_data    (out_bits)
  );

  assign m_tdata = {(24 - jjy_pkg::RESULT_BITS)'(0), out_bits};

endmodule

// File: rtl/jjy_symbol.sv
// symbol encoder: picks the jjy symbol and carrier width for the current second
// depends on jjy_pkg

module jjy_symbol (
  input  jjy_pkg::time_state_t st,
  input  jjy_pkg::widths_t     widths,
  output logic [1:0]           symbol,
  output logic [9:0]           high_ms,
  output logic [5:0]           position
);

  logic [63:0] frame;
  logic        quiet;
  logic        marker;
  logic [5:0]  pos;

  assign pos   = st.second;
  assign quiet = (st.minute == jjy_pkg::QUIET_MIN_A) || (st.minute == jjy_pkg::QUIET_MIN_B);

  assign marker = (pos == 6'd0) || (pos == 6'd9) || (pos == 6'd19) || (pos == 6'd29) ||
                  (pos == 6'd39) || (pos == 6'd49) || (pos == 6'd59);

  // data bits laid out at their frame positions
  always_comb begin
    frame = '0;
    frame[3:1]   = {st.minute[4], st.minute[5], st.minute[6]};
    frame[8:5]   = {st.minute[0], st.minute[1], st.minute[2], st.minute[3]};
    frame[13:12] = {st.hour[4], st.hour[5]};
    frame[18:15] = {st.hour[0], st.hour[1], st.hour[2], st.hour[3]};
    frame[23:22] = {st.day[8], st.day[9]};
    frame[28:25] = {st.day[4], st.day[5], st.day[6], st.day[7]};
    frame[33:30] = {st.day[0], st.day[1], st.day[2], st.day[3]};
    frame[36]    = ^st.hour;
    frame[37]    = ^st.minute;
    if (!quiet) begin
      for (int i = 0; i < 8; i++) begin
        frame[48 - i] = st.year[i];
      end
      for (int i = 0; i < 3; i++) begin
        frame[52 - i] = st.weekday[i];
      end
    end
  end

  always_comb begin
    position = pos;
    if (marker) begin
      symbol  = jjy_pkg::SYM_MARKER;
      high_ms = widths.marker_ms;
    end else if (frame[pos]) begin
      symbol  = jjy_pkg::SYM_ONE;
      high_ms = widths.one_ms;
    end else begin
      symbol  = jjy_pkg::SYM_ZERO;
      high_ms = widths.zero_ms;
    end
  end

endmodule

// File: rtl/jjy_timekeeper.sv
// time state registers: load with saturation and year wrap, second advance and bcd rollover
// depends on jjy_pkg

module jjy_timekeeper (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick,
  input  logic                 load,
  input  logic [6:0]           set_year,
  input  logic [8:0]           set_day_of_year,
  input  logic [4:0]           set_hour,
  input  logic [5:0]           set_minute,
  input  logic [5:0]           set_second,
  input  logic [2:0]           set_weekday,
  output jjy_pkg::time_state_t st,
  output logic                 resync_next
);

  jjy_pkg::time_state_t st_next;
  jjy_pkg::time_state_t adv;
  jjy_pkg::time_state_t ld;

  logic [6:0]  year_mod;
  logic [8:0]  day_sat;
  logic [11:0] year_dig;
  logic [11:0] day_dig;
  logic [11:0] hour_dig;
  logic [11:0] min_dig;

  // load path
  always_comb begin
    year_mod = (set_year >= 7'd100) ? 7'(set_year - 7'd100) : set_year;
    if (set_day_of_year == 9'd0) begin
      day_sat = 9'd1;
    end else if (set_day_of_year > 9'd366) begin
      day_sat = 9'd366;
    end else begin
      day_sat = set_day_of_year;
    end
    year_dig = jjy_pkg::bin_to_bcd3({2'b00, year_mod});
    day_dig  = jjy_pkg::bin_to_bcd3(day_sat);
    hour_dig = jjy_pkg::bin_to_bcd3((set_hour > 5'd23) ? 9'd23 : {4'b0, set_hour});
    min_dig  = jjy_pkg::bin_to_bcd3((set_minute > 6'd59) ? 9'd59 : {3'b0, set_minute});
    ld.year    = year_dig[7:0];
    ld.day     = day_dig[9:0];
    ld.hour    = hour_dig[5:0];
    ld.minute  = min_dig[6:0];
    ld.second  = (set_second > jjy_pkg::SECOND_LAST) ? jjy_pkg::SECOND_LAST : set_second;
    ld.weekday = set_weekday;
    ld.resync  = 1'b0;
  end

  // tick path
  always_comb begin
    adv = st;
    if (st.second >= jjy_pkg::SECOND_LAST) begin
      adv.second = 6'd0;
      if (!st.resync) begin
        if (st.minute == jjy_pkg::MINUTE_LAST_BCD) begin
          adv.minute = 7'h00;
          if (st.hour == jjy_pkg::HOUR_LAST_BCD) begin
            adv.hour = 6'h00;
            if (st.day >= jjy_pkg::DAY_LAST_BCD) begin
              adv.resync = 1'b1;
            end else begin
              if (st.day[3:0] != 4'd9) begin
                adv.day[3:0] = st.day[3:0] + 4'd1;
              end else if (st.day[7:4] != 4'd9) begin
                adv.day[3:0] = 4'd0;
                adv.day[7:4] = st.day[7:4] + 4'd1;
              end else begin
                adv.day[7:0] = 8'h00;
                adv.day[9:8] = st.day[9:8] + 2'd1;
              end
              adv.weekday = (st.weekday >= jjy_pkg::WEEKDAY_LAST) ? 3'd0 : st.weekday + 3'd1;
            end
          end else if (st.hour[3:0] == 4'd9) begin
            adv.hour = {st.hour[5:4] + 2'd1, 4'd0};
          end else begin
            adv.hour = st.hour + 6'd1;
          end
        end else if (st.minute[3:0] == 4'd9) begin
          adv.minute = {st.minute[6:4] + 3'd1, 4'd0};
        end else begin
          adv.minute = st.minute + 7'd1;
        end
      end
    end else begin
      adv.second = st.second + 6'd1;
    end
  end

  always_comb begin
    if (load) begin
      st_next = ld;
    end else if (tick) begin
      st_next = adv;
    end else begin
      st_next = st;
    end
  end

  assign resync_next = adv.resync;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{second: 6'd0, minute: 7'h00, hour: 6'h00, day: 10'h001,
              year: 8'h00, weekday: 3'd0, resync: 1'b0};
    end else begin
      st <= st_next;
    end
  end

endmodule

// File: rtl/jjy_out_skid.sv
// two-entry output buffer: result register plus skid register
// depends on jjy_pkg

module jjy_out_skid (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  jjy_pkg::result_t               push_data,
  output logic                           space,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [jjy_pkg::RESULT_BITS-1:0] m_data
);

  jjy_pkg::result_t out_reg;
  jjy_pkg::result_t skid_reg;
  logic             out_valid;
  logic             skid_valid;
  logic             pop;

  assign pop      = out_valid && m_tready;
  assign space    = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_data   = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // payload moves without reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_reg <= skid_reg;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_reg <= push_data;
      end else begin
        skid_reg <= push_data;
      end
    end
  end

endmodule

// File: rtl/jjy_checker.sv
// port-level checks for the jjy time code generator
// depends on jjy_pkg and jjy_time_code_generator_unit; bound to it below

module jjy_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // marker positions always carry the marker symbol
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[17:12] == 6'd0 || m_tdata[17:12] == 6'd9 ||
                 m_tdata[17:12] == 6'd19 || m_tdata[17:12] == 6'd29 ||
                 m_tdata[17:12] == 6'd39 || m_tdata[17:12] == 6'd49 ||
                 m_tdata[17:12] == 6'd59)
    |-> m_tdata[1:0] == jjy_pkg::SYM_MARKER)
    else $error("marker position without marker symbol");

  // input back-pressure only while a result is waiting
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // reset empties the output
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind jjy_time_code_generator_unit jjy_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: bench/tb_jjy_time_code_generator_unit.sv
`timescale 1ns / 1ps
// self-checking bench for jjy_time_code_generator_unit: predicts every symbol of the
// frame from its own copy of the time of day; depends on jjy_pkg and the rtl top

module tb_jjy_time_code_generator_unit;

  localparam int unsigned RANDOM_ITEMS   = 1200;
  localparam int unsigned HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles with no transaction at all
  localparam int unsigned SETTLE_CYCLES  = 4;     // margin after the last owed symbol
  localparam logic [1:0]  REG_UNUSED     = 2'd3;  // index with no register behind it

  // fields of a load, packed as on s_tdata (year in the low bits)
  typedef struct packed {
    logic [2:0] weekday;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [8:0] day;
    logic [6:0] year;
  } time_set_t;

  // predicted time of day, bcd like the block keeps it
  typedef struct {
    bit [5:0] second;
    bit [6:0] minute;
    bit [5:0] hour;
    bit [9:0] day;
    bit [7:0] year;
    bit [2:0] weekday;
    bit       resync;
  } tod_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = jjy_pkg::OP_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = jjy_pkg::REG_MARKER_MS;
  logic [9:0]  cfg_data = '0;

  // predictor state
  tod_t     tod = '{second: 6'd0, minute: 7'h00, hour: 6'h00, day: 10'h001,
                    year: 8'h00, weekday: 3'd0, resync: 1'b0};
  bit [9:0] w_marker = jjy_pkg::MARKER_MS_RESET;
  bit [9:0] w_one    = jjy_pkg::ONE_MS_RESET;
  bit [9:0] w_zero   = jjy_pkg::ZERO_MS_RESET;

  jjy_pkg::result_t symbol_q[$];  // symbols still owed by the block, oldest first
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;

  // idling controls; tx_idle is only read by the sending thread
  bit          tx_idle = 1'b1;
  logic        rx_idle = 1'b1;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_gap = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  jjy_time_code_generator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    // year[6:0], day[15:7], hour[20:16], minute[26:21], second[32:27], weekday[35:33]
    .s_tdata   (s_tdata),
    // operation
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    // symbol[1:0], high_ms[11:2], position[17:12], resync_request[18]
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  function automatic bit [11:0] bcd_pack(int unsigned v);
    return {4'(v / 100), 4'((v / 10) % 10), 4'(v % 10)};
  endfunction

  function automatic int unsigned bcd_value(bit [11:0] b);
    return b[11:8] * 100 + b[7:4] * 10 + b[3:0];
  endfunction

  // data bit of a non-marker position; reserved positions carry zero
  function automatic bit frame_bit(int unsigned pos);
    bit [6:0] m;
    bit [5:0] h;
    bit [9:0] d;
    bit [7:0] y;
    m = tod.minute;
    h = tod.hour;
    d = tod.day;
    y = tod.year;
    // quarter-hour minutes blank out year and weekday (49 is caught as marker earlier)
    if ((m == jjy_pkg::QUIET_MIN_A || m == jjy_pkg::QUIET_MIN_B) &&
        pos >= 40 && pos <= 52) return 1'b0;
    if (pos >= 1 && pos <= 3)   return m[7 - pos];
    if (pos >= 5 && pos <= 8)   return m[8 - pos];
    if (pos >= 12 && pos <= 13) return h[17 - pos];
    if (pos >= 15 && pos <= 18) return h[18 - pos];
    if (pos >= 22 && pos <= 23) return d[31 - pos];
    if (pos >= 25 && pos <= 28) return d[32 - pos];
    if (pos >= 30 && pos <= 33) return d[33 - pos];
    if (pos == 36)              return ^h;
    if (pos == 37)              return ^m;
    if (pos >= 41 && pos <= 48) return y[48 - pos];
    if (pos >= 50 && pos <= 52) return tod.weekday[52 - pos];
    return 1'b0;
  endfunction

  // minute carry into hour, day and weekday; frozen while a resync is pending
  function automatic void roll_minute();
    int unsigned v;
    if (tod.resync) return;
    v = bcd_value(12'(tod.minute)) + 1;
    if (v < 60) begin
      tod.minute = 7'(bcd_pack(v));
      return;
    end
    tod.minute = '0;
    v = bcd_value(12'(tod.hour)) + 1;
    if (v < 24) begin
      tod.hour = 6'(bcd_pack(v));
      return;
    end
    tod.hour = '0;
    v = bcd_value(12'(tod.day)) + 1;
    // past the last day of the year: hold day and weekday, ask for a reload
    if (v > 365) begin
      tod.resync = 1'b1;
      return;
    end
    tod.day = 10'(bcd_pack(v));
    tod.weekday = (tod.weekday >= jjy_pkg::WEEKDAY_LAST) ? 3'd0 : tod.weekday + 3'd1;
  endfunction

  function automatic jjy_pkg::result_t next_symbol();
    jjy_pkg::result_t r;
    int unsigned      pos;
    pos = tod.second;
    if (pos == 0 || pos == 59 || pos % 10 == 9) begin
      r.symbol  = jjy_pkg::SYM_MARKER;
      r.high_ms = w_marker;
    end else if (frame_bit(pos)) begin
      r.symbol  = jjy_pkg::SYM_ONE;
      r.high_ms = w_one;
    end else begin
      r.symbol  = jjy_pkg::SYM_ZERO;
      r.high_ms = w_zero;
    end
    r.position = 6'(pos);
    if (tod.second >= jjy_pkg::SECOND_LAST) begin
      tod.second = '0;
      roll_minute();
    end else begin
      tod.second = tod.second + 6'd1;
    end
    r.resync_request = tod.resync;
    return r;
  endfunction

  // out-of-range load fields saturate, year wraps modulo 100, day 0 becomes 1
  function automatic void apply_load(logic [35:0] fields);
    time_set_t   ts;
    int unsigned d;
    ts = fields;
    tod.year = 8'(bcd_pack(ts.year % 100));
    d = ts.day;
    if (d == 0) d = 1;
    else if (d > 366) d = 366;
    tod.day     = 10'(bcd_pack(d));
    tod.hour    = 6'(bcd_pack(ts.hour > 23 ? 23 : ts.hour));
    tod.minute  = 7'(bcd_pack(ts.minute > 59 ? 59 : ts.minute));
    tod.second  = (ts.second > jjy_pkg::SECOND_LAST) ? jjy_pkg::SECOND_LAST : ts.second;
    tod.weekday = ts.weekday;
    tod.resync  = 1'b0;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // idle length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [35:0] time_fields(int unsigned yr, int unsigned dy,
                                              int unsigned hr, int unsigned mi,
                                              int unsigned se, int unsigned wd);
    time_set_t ts;
    ts.year    = 7'(yr);
    ts.day     = 9'(dy);
    ts.hour    = 5'(hr);
    ts.minute  = 6'(mi);
    ts.second  = 6'(se);
    ts.weekday = 3'(wd);
    return ts;
  endfunction

  // one input transaction; the expectation is formed at the accepting edge
  task automatic send_txn(input logic op, input logic [35:0] fields);
    int unsigned gap;
    gap = tx_idle ? idle_len() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, fields};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (op == jjy_pkg::OP_LOAD) apply_load(fields);
    else symbol_q.push_back(next_symbol());
  endtask

  task automatic send_load(input logic [35:0] fields);
    send_txn(jjy_pkg::OP_LOAD, fields);
  endtask

  // tick payload is ignored by the block, so it carries noise
  task automatic send_ticks(input int unsigned count);
    repeat (count) send_txn(jjy_pkg::OP_TICK, 36'({$urandom, $urandom}));
  endtask

  // stop offering, wait for every owed symbol, then let the pipeline settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (symbol_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; cfg_we drops again before the task returns
  task automatic write_reg(input logic [1:0] index, input logic [9:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    case (index)
      jjy_pkg::REG_MARKER_MS: w_marker = value;
      jjy_pkg::REG_ONE_MS:    w_one    = value;
      jjy_pkg::REG_ZERO_MS:   w_zero   = value;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [9:0] random_width();
    case ($urandom_range(0, 5))
      0:       return 10'd0;
      1:       return 10'd1023;
      2:       return 10'd1000;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // random load, leaning toward rollover corners and quiet minutes
  function automatic logic [35:0] random_setting();
    int unsigned yr;
    int unsigned dy;
    int unsigned hr;
    int unsigned mi;
    int unsigned se;
    yr = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 99) : $urandom_range(100, 127);
    case ($urandom_range(0, 9))
      0:       dy = 365;
      1:       dy = 366;
      2:       dy = 0;
      3:       dy = $urandom_range(367, 511);
      default: dy = $urandom_range(1, 366);
    endcase
    case ($urandom_range(0, 5))
      0, 1:    hr = 23;
      2:       hr = $urandom_range(24, 31);
      default: hr = $urandom_range(0, 23);
    endcase
    case ($urandom_range(0, 9))
      0, 1:    mi = 59;
      2:       mi = 14;
      3:       mi = 44;
      4:       mi = ($urandom_range(0, 1) != 0) ? 15 : 45;
      5:       mi = $urandom_range(60, 63);
      default: mi = $urandom_range(0, 59);
    endcase
    case ($urandom_range(0, 5))
      0, 1:    se = $urandom_range(55, 59);
      2:       se = $urandom_range(60, 63);
      default: se = $urandom_range(0, 59);
    endcase
    return time_fields(yr, dy, hr, mi, se, $urandom_range(0, 7));
  endfunction

  // ---------------------------------------------------------------- tests

  // frame start straight out of reset: marker at 0, then zero bits
  task automatic test_reset_frame();
    send_ticks(3);
  endtask

  // every field at its top bit pattern, then everything at zero
  task automatic test_load_extremes();
    // saturates to day 366 23:59:59, weekday 7; the tick rolls into a resync
    send_load(time_fields(127, 511, 31, 63, 63, 7));
    send_ticks(2);
    // day 0 loads as day one and the load drops the resync request
    send_load(time_fields(0, 0, 0, 0, 0, 0));
    send_ticks(1);
  endtask

  task automatic test_quiet_and_parity();
    // quarter-hour minute: year and weekday blanked, 49 stays a marker
    send_load(time_fields(99, 365, 23, 45, 48, 6));
    send_ticks(4);
    // both parity bits over an odd number of ones
    send_load(time_fields(99, 200, 23, 15, 35, 1));
    send_ticks(4);
    // weekday 7 is sent as is
    send_load(time_fields(42, 17, 8, 12, 50, 7));
    send_ticks(3);
  endtask

  task automatic test_width_extremes();
    drain_results();
    write_reg(jjy_pkg::REG_MARKER_MS, 10'd0);
    write_reg(jjy_pkg::REG_ONE_MS, 10'd1023);
    write_reg(jjy_pkg::REG_ZERO_MS, 10'd1000);
    write_reg(REG_UNUSED, 10'h2AA);
    send_load(time_fields(55, 255, 13, 37, 7, 3));
    send_ticks(3);
    drain_results();
    write_reg(jjy_pkg::REG_MARKER_MS, 10'd1023);
    write_reg(jjy_pkg::REG_ONE_MS, 10'd0);
    write_reg(jjy_pkg::REG_ZERO_MS, 10'h155);
    send_ticks(3);
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    drain_results();
    tx_idle = 1'b0;
    hold_token <= hold_token + 1;
    send_load(time_fields(33, 120, 10, 59, 30, 4));
    send_ticks(40);
    tx_idle = 1'b1;
    // sender sits out until every symbol is back
    drain_results();
  endtask

  task automatic test_random_frames();
    int unsigned done;
    int unsigned r;
    int unsigned mode;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      drain_results();
      if ($urandom_range(0, 2) != 0) begin
        write_reg(jjy_pkg::REG_MARKER_MS, random_width());
        write_reg(jjy_pkg::REG_ONE_MS, random_width());
        write_reg(jjy_pkg::REG_ZERO_MS, random_width());
      end
      // idling per phase: none, sender only, receiver only, both
      mode = $urandom_range(0, 3);
      tx_idle = (mode == 1 || mode == 3);
      rx_idle <= (mode == 2 || mode == 3);
      repeat (4) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          // year end: run into the day rollover and a pending resync
          send_load(time_fields($urandom_range(0, 99), $urandom_range(365, 366), 23, 59,
                                $urandom_range(40, 59), $urandom_range(0, 7)));
          r = $urandom_range(20, 90);
          send_ticks(r);
          done += r + 1;
        end else if (r < 85) begin
          send_load(random_setting());
          r = $urandom_range(20, 130);
          send_ticks(r);
          done += r + 1;
        end else if (r < 93) begin
          r = $urandom_range(1, 5);
          send_ticks(r);
          done += r;
        end else begin
          // load overwritten before any tick
          send_load(random_setting());
          send_load(random_setting());
          r = $urandom_range(1, 3);
          send_ticks(r);
          done += r + 2;
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle <= 1'b1;
  endtask

  // ---------------------------------------------------------------- receiver

  // long hold on request, otherwise random gaps when rx_idle is set
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      rx_hold   <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (!rx_idle) begin
      m_tready <= 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap   <= rx_gap - 1;
      m_tready <= 1'b0;
    end else begin : pick_gap
      int unsigned n;
      n = idle_len();
      if (n == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_gap   <= n - 1;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  // each result transaction against the oldest owed symbol, field by field
  always @(posedge clk) begin : check_results
    jjy_pkg::result_t got;
    jjy_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[jjy_pkg::RESULT_BITS-1:0];
      if (symbol_q.size() == 0) begin
        report_mismatch("unexpected result", '0, 32'(m_tdata));
      end else begin
        want = symbol_q.pop_front();
        if (got.symbol !== want.symbol)
          report_mismatch("symbol", 32'(want.symbol), 32'(got.symbol));
        if (got.high_ms !== want.high_ms)
          report_mismatch("high_ms", 32'(want.high_ms), 32'(got.high_ms));
        if (got.position !== want.position)
          report_mismatch("position", 32'(want.position), 32'(got.position));
        if (got.resync_request !== want.resync_request)
          report_mismatch("resync_request", 32'(want.resync_request),
                          32'(got.resync_request));
      end
    end
  end

  // watchdog on cycles in which no transaction moves on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_frame();
    test_load_extremes();
    test_quiet_and_parity();
    test_width_extremes();
    test_backpressure();
    test_random_frames();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && symbol_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
